@@ rtl/core/cmi_pkg.sv @@
// ----------------------------------------------------------------------------
// Colour map interpolator package
// Shared types, widths and fixed colours of the colour map interpolator.
// ----------------------------------------------------------------------------
package cmi_pkg;

  // Table size and position format.
  localparam int MaxKeys  = 16;
  localparam int FracBits = 8;

  localparam int SampleW = 32;
  localparam int ChanW   = 8;
  localparam int ColourW = 4 * ChanW;
  localparam int KeyW    = $clog2(MaxKeys);
  localparam int PosW    = KeyW + FracBits;
  localparam int NumW    = SampleW + KeyW;

  // Fixed colours of the special cases.
  localparam logic [ChanW-1:0] GreyLevel = 8'd179;
  localparam logic [ChanW-1:0] FullLevel = 8'd255;
  localparam logic [ChanW-1:0] PinkBlue  = 8'd128;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_MAP   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_INTERP = 2'd0,
    KIND_GREY   = 2'd1,
    KIND_PINK   = 2'd2
  } colour_kind_e;

  typedef enum logic [1:0] {
    CFG_KEY_MIN   = 2'd0,
    CFG_KEY_MAX   = 2'd1,
    CFG_KEY_COUNT = 2'd2,
    CFG_USE_ALPHA = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    cmd_e               command;
    logic signed [31:0] sample_value;
    logic [3:0]         entry_index;
    logic [7:0]         entry_red;
    logic [7:0]         entry_green;
    logic [7:0]         entry_blue;
    logic [7:0]         entry_alpha;
  } cmi_in_t;

  typedef struct packed {
    logic [7:0]   red;
    logic [7:0]   green;
    logic [7:0]   blue;
    logic [7:0]   alpha;
    colour_kind_e colour_kind;
  } cmi_out_t;

  // Information that travels beside the divider.
  typedef struct packed {
    cmd_e               command;
    colour_kind_e       kind;
    logic [3:0]         entry_index;
    logic [ColourW-1:0] entry_colour;
  } cmi_side_t;

endpackage

@@ rtl/core/cmi_div_pipe.sv @@
// ----------------------------------------------------------------------------
// Colour map interpolator divider pipeline
// Restoring division of the scaled offset by the key span, one quotient bit
// per stage, with the transaction's side information carried alongside.
// ----------------------------------------------------------------------------
module cmi_div_pipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  cmi_pkg::cmi_side_t side_i,
  input  logic [cmi_pkg::NumW-1:0]    num_i,
  input  logic [cmi_pkg::SampleW-1:0] span_i,
  output logic               vld_o,
  output cmi_pkg::cmi_side_t side_o,
  output logic [cmi_pkg::PosW-1:0]    quot_o
);
  import cmi_pkg::*;

  logic              vld_q  [PosW];
  cmi_side_t         side_q [PosW];
  logic [SampleW-1:0] rem_q [PosW];
  logic [PosW-1:0]   low_q  [PosW];
  logic [PosW-1:0]   quot_q [PosW];

  logic [SampleW-1:0] rem_in  [PosW];
  logic [PosW-1:0]    low_in  [PosW];
  logic [PosW-1:0]    quot_in [PosW];
  logic [SampleW:0]   trial   [PosW];
  logic [SampleW:0]   diff    [PosW];
  logic               ge      [PosW];
  logic [SampleW-1:0] rem_d   [PosW];
  logic [PosW-1:0]    low_d   [PosW];
  logic [PosW-1:0]    quot_d  [PosW];

  // Each stage shifts in one dividend bit and subtracts the span if it fits.
  // The upper dividend bits start below the span, so the quotient fits PosW.
  always_comb begin
    for (int s = 0; s < PosW; s++) begin
      if (s == 0) begin
        rem_in[s]  = num_i[NumW-1:KeyW];
        low_in[s]  = {num_i[KeyW-1:0], {FracBits{1'b0}}};
        quot_in[s] = '0;
      end else begin
        rem_in[s]  = rem_q[s-1];
        low_in[s]  = low_q[s-1];
        quot_in[s] = quot_q[s-1];
      end
      trial[s]  = {rem_in[s], low_in[s][PosW-1]};
      diff[s]   = trial[s] - {1'b0, span_i};
      ge[s]     = trial[s] >= {1'b0, span_i};
      rem_d[s]  = ge[s] ? diff[s][SampleW-1:0] : trial[s][SampleW-1:0];
      low_d[s]  = {low_in[s][PosW-2:0], 1'b0};
      quot_d[s] = {quot_in[s][PosW-2:0], ge[s]};
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < PosW; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int s = 1; s < PosW; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  // Stage data.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 1; s < PosW; s++) begin
        side_q[s] <= side_q[s-1];
      end
      for (int s = 0; s < PosW; s++) begin
        rem_q[s]  <= rem_d[s];
        low_q[s]  <= low_d[s];
        quot_q[s] <= quot_d[s];
      end
    end
  end

  assign vld_o  = vld_q[PosW-1];
  assign side_o = side_q[PosW-1];
  assign quot_o = quot_q[PosW-1];

endmodule

@@ rtl/core/colour_map_interpolator_core.sv @@
// ----------------------------------------------------------------------------
// Colour map interpolator core
// Maps signed Q16.16 samples to RGBA colours by linear interpolation over a
// table of up to 16 key colours held in a small synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions (in_valid_i / in_stall_o) carry either a key colour
//   write (command 0) or a sample to map (command 1). Writes produce no
//   output; each map produces one output transaction (out_valid_o /
//   out_stall_i) in the same order as the samples were accepted.
//   A table entry must be written before a sample maps onto it.
//   Pipeline: input register, range check, scaling multiply, 12 divider
//   stages (one quotient bit each), table read, then the interpolated output
//   register. Throughput: one transaction per cycle while the pipeline is
//   not held; the divider pipeline sets the latency and the dual-read table
//   port reads both key colours at once.
//   When the receiver stalls, one further result is caught in a skid
//   register; once that is full, in_stall_o rises and the whole pipeline
//   holds. Key colour writes pass through the same pipeline and update the
//   table at the read stage, so reads and writes stay in order.
//   Configuration is written through cfg_we_i while no transaction is in
//   flight. Reset clears the pipeline and loads the register defaults; the
//   table contents stay undefined until written.
// ----------------------------------------------------------------------------
module colour_map_interpolator_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cmi_pkg::cmi_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cmi_pkg::cmi_out_t out_data_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [31:0]      cfg_wdata_i
);
  import cmi_pkg::*;

  // Configuration registers and derived values.
  logic signed [SampleW-1:0] key_min_q, key_max_q;
  logic [4:0]                key_count_q;
  logic                      use_alpha_q;
  logic [SampleW-1:0]        span_q;
  logic [KeyW-1:0]           nm1_q;
  logic [KeyW-1:0]           nm1_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_min_q   <= '0;
      key_max_q   <= 32'sd16711680;
      key_count_q <= 5'd2;
      use_alpha_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_KEY_MIN:   key_min_q   <= cfg_wdata_i;
        CFG_KEY_MAX:   key_max_q   <= cfg_wdata_i;
        CFG_KEY_COUNT: key_count_q <= cfg_wdata_i[4:0];
        CFG_USE_ALPHA: use_alpha_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Out-of-range key counts are clamped to the usable range.
  always_comb begin
    if (key_count_q < 5'd2) begin
      nm1_d = KeyW'(1);
    end else if (32'(key_count_q) > MaxKeys) begin
      nm1_d = KeyW'(MaxKeys - 1);
    end else begin
      nm1_d = KeyW'(key_count_q - 5'd1);
    end
  end

  // The span and key count minus one are registered from the configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q <= 32'd16711680;
      nm1_q  <= KeyW'(1);
    end else begin
      span_q <= SampleW'(key_max_q - key_min_q);
      nm1_q  <= nm1_d;
    end
  end

  // Output register and skid register.
  logic     out_valid_q, skid_valid_q;
  cmi_out_t out_data_q, skid_data_q;
  logic     adv;

  assign adv        = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // Input register.
  logic    a_vld_q;
  cmi_in_t a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      a_q <= in_data_i;
    end
  end

  // Range check and offset from the first key.
  logic               is_pink, is_grey;
  logic [SampleW:0]   offset;
  cmi_side_t          b_side_d;

  always_comb begin
    is_pink = key_min_q == key_max_q;
    is_grey = (a_q.sample_value < key_min_q) || (a_q.sample_value > key_max_q);
    offset  = {a_q.sample_value[SampleW-1], a_q.sample_value}
              - {key_min_q[SampleW-1], key_min_q};
    b_side_d.command      = a_q.command;
    b_side_d.kind         = is_pink ? KIND_PINK : (is_grey ? KIND_GREY : KIND_INTERP);
    b_side_d.entry_index  = a_q.entry_index;
    b_side_d.entry_colour = {a_q.entry_red, a_q.entry_green, a_q.entry_blue,
                             a_q.entry_alpha};
  end

  logic               b_vld_q;
  cmi_side_t          b_side_q;
  logic [SampleW-1:0] b_offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (adv) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_side_q   <= b_side_d;
      b_offset_q <= offset[SampleW-1:0];
    end
  end

  // Scale the offset by the number of segments.
  logic            c_vld_q;
  cmi_side_t       c_side_q;
  logic [NumW-1:0] c_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (adv) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_side_q <= b_side_q;
      c_num_q  <= NumW'(b_offset_q) * NumW'(nm1_q);
    end
  end

  // Position along the table: scaled offset divided by the span.
  logic            d_vld;
  cmi_side_t       d_side;
  logic [PosW-1:0] d_quot;

  cmi_div_pipe u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (c_vld_q),
    .side_i (c_side_q),
    .num_i  (c_num_q),
    .span_i (span_q),
    .vld_o  (d_vld),
    .side_o (d_side),
    .quot_o (d_quot)
  );

  // Clamp the position below the last key and split segment and fraction.
  logic [PosW-1:0]     pos_limit, pos;
  logic [KeyW-1:0]     seg, seg_next;
  logic [FracBits-1:0] frac;

  always_comb begin
    pos_limit = {nm1_q, {FracBits{1'b0}}} - PosW'(1);
    pos       = (d_quot > pos_limit) ? pos_limit : d_quot;
    seg       = pos[PosW-1:FracBits];
    seg_next  = seg + KeyW'(1);
    frac      = pos[FracBits-1:0];
  end

  // Key colour table: writes and both reads happen in the same stage, so
  // accesses keep transaction order and no forwarding is needed.
  logic [ColourW-1:0]  table_mem [MaxKeys];
  logic [ColourW-1:0]  rd0_q, rd1_q;
  logic                r_vld_q;
  cmi_side_t           r_side_q;
  logic [FracBits-1:0] r_frac_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (d_vld && d_side.command == CMD_WRITE && 32'(d_side.entry_index) < MaxKeys) begin
        table_mem[KeyW'(d_side.entry_index)] <= d_side.entry_colour;
      end
      rd0_q    <= table_mem[seg];
      rd1_q    <= table_mem[seg_next];
      r_side_q <= d_side;
      r_frac_q <= frac;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= 1'b0;
    end else if (adv) begin
      r_vld_q <= d_vld;
    end
  end

  // Linear blend of one channel, with the step rounded toward minus infinity.
  function automatic logic [ChanW-1:0] lerp_chan(input logic [ChanW-1:0] c0,
                                                 input logic [ChanW-1:0] c1,
                                                 input logic [FracBits-1:0] f);
    logic signed [ChanW:0]            dlt;
    logic signed [ChanW+FracBits+1:0] prod;
    logic signed [ChanW:0]            step;
    logic signed [ChanW:0]            sum;
    dlt  = $signed({1'b0, c1}) - $signed({1'b0, c0});
    prod = (ChanW+FracBits+2)'(dlt) * (ChanW+FracBits+2)'($signed({1'b0, f}));
    step = (ChanW+1)'(prod >>> FracBits);
    sum  = $signed({1'b0, c0}) + step;
    return sum[ChanW-1:0];
  endfunction

  // Final colour of the transaction in the read stage.
  cmi_out_t res;
  logic     res_vld;

  always_comb begin
    res_vld = r_vld_q && r_side_q.command == CMD_MAP;
    res.colour_kind = r_side_q.kind;
    case (r_side_q.kind)
      KIND_PINK: begin
        res.red   = FullLevel;
        res.green = '0;
        res.blue  = PinkBlue;
        res.alpha = FullLevel;
      end
      KIND_GREY: begin
        res.red   = GreyLevel;
        res.green = GreyLevel;
        res.blue  = GreyLevel;
        res.alpha = FullLevel;
      end
      default: begin
        res.red   = lerp_chan(rd0_q[31:24], rd1_q[31:24], r_frac_q);
        res.green = lerp_chan(rd0_q[23:16], rd1_q[23:16], r_frac_q);
        res.blue  = lerp_chan(rd0_q[15:8], rd1_q[15:8], r_frac_q);
        res.alpha = use_alpha_q ? lerp_chan(rd0_q[7:0], rd1_q[7:0], r_frac_q)
                                : FullLevel;
      end
    endcase
  end

  // Output register with a skid register behind it. The skid register only
  // fills while the output is held, and while it is full the pipeline holds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_vld;
      end
    end else if (res_vld && adv) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
      end else if (res_vld) begin
        out_data_q <= res;
      end
    end else if (res_vld && adv) begin
      skid_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ rtl/core/cmi_checker.sv @@
// ----------------------------------------------------------------------------
// Colour map interpolator port checker
// Checks the output handshake and the fixed special-case colours as seen on
// the ports of the core, and is bound to every instance of the core.
// ----------------------------------------------------------------------------
module cmi_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input cmi_pkg::cmi_out_t out_data_o
);
  import cmi_pkg::*;

  // A stalled output transaction stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  // A stalled output transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // The input only stalls when a result is already waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty output");

  // Out-of-range results carry the fixed grey.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.colour_kind == KIND_GREY |->
      out_data_o.red == GreyLevel && out_data_o.green == GreyLevel &&
      out_data_o.blue == GreyLevel && out_data_o.alpha == FullLevel)
    else $error("grey result with wrong colour");

  // Degenerate-range results carry the fixed pink.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.colour_kind == KIND_PINK |->
      out_data_o.red == FullLevel && out_data_o.green == 8'd0 &&
      out_data_o.blue == PinkBlue && out_data_o.alpha == FullLevel)
    else $error("pink result with wrong colour");

endmodule

bind colour_map_interpolator_core cmi_checker u_cmi_checker (.*);
